// ===== rtl/vms_pkg.sv =====
package vms_pkg;

	// Widest signed difference of two inputs at the largest supported stress width.
	localparam int DIFF_W     = 33;
	// A magnitude at or above 2**MAG_W can only end in a saturated result.
	localparam int MAG_W      = 30;
	// A square is at most 2**60, so it needs one more bit than MAG_W squared.
	localparam int SQ_W       = 2 * MAG_W + 1;
	// A sum of three squares.
	localparam int SUM_W      = SQ_W + 1;
	// The combined invariant.
	localparam int Q_W        = 64;
	// Result width, and the radicand width below which the root is exact.
	localparam int ROOT_W     = 26;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 1;
	localparam int ROOT_STEPS = ROOT_W;

	localparam logic [SQ_W-1:0] SQ_CAP = SQ_W'(1) << (2 * MAG_W);

	// One item in flight along the root chain.
	typedef struct packed {
		logic              valid;
		logic              sat;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_step_t;

endpackage

// ===== rtl/vms_front.sv =====
module vms_front #(
	parameter int STRESS_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic                           full_3d,
	input  logic signed [STRESS_WIDTH-1:0] normal_x,
	input  logic signed [STRESS_WIDTH-1:0] normal_y,
	input  logic signed [STRESS_WIDTH-1:0] normal_z,
	input  logic signed [STRESS_WIDTH-1:0] shear_xy,
	input  logic signed [STRESS_WIDTH-1:0] shear_yz,
	input  logic signed [STRESS_WIDTH-1:0] shear_xz,
	output vms_pkg::root_step_t            step_o
);

	localparam int DW = vms_pkg::DIFF_W;
	localparam int MW = vms_pkg::MAG_W;
	localparam int SW = vms_pkg::SQ_W;
	localparam int UW = vms_pkg::SUM_W;
	localparam int QW = vms_pkg::Q_W;
	localparam int RW = vms_pkg::RAD_W;

	logic signed [DW-1:0] xx_ext, yy_ext, zz_ext, xy_ext, yz_ext, xz_ext;
	logic signed [DW-1:0] term_s1 [6];
	logic [MW-1:0]        mag_s2 [6];
	logic                 cap_s2 [6];
	logic [SW-1:0]        sq_s3 [6];
	logic [UW-1:0]        normal_s4, shear_s4;
	logic [QW-1:0]        q_sum;
	logic                 sat_s5;
	logic [RW-1:0]        rad_s5;
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;

	// Sign extension to the common width; plane mode drops the out-of-plane terms.
	assign xx_ext = DW'(normal_x);
	assign yy_ext = DW'(normal_y);
	assign zz_ext = full_3d ? DW'(normal_z) : '0;
	assign xy_ext = DW'(shear_xy);
	assign yz_ext = full_3d ? DW'(shear_yz) : '0;
	assign xz_ext = full_3d ? DW'(shear_xz) : '0;

	// Valid bits of the five stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: normal differences and shear terms.
	always_ff @(posedge clk) begin
		if (en) begin
			term_s1[0] <= xx_ext - yy_ext;
			term_s1[1] <= yy_ext - zz_ext;
			term_s1[2] <= zz_ext - xx_ext;
			term_s1[3] <= xy_ext;
			term_s1[4] <= yz_ext;
			term_s1[5] <= xz_ext;
		end
	end

	// Stage 2: magnitudes, flagged once they are large enough to saturate.
	always_ff @(posedge clk) begin
		logic [DW-1:0] mag;
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				mag       = term_s1[i][DW-1] ? DW'(-term_s1[i]) : DW'(term_s1[i]);
				mag_s2[i] <= mag[MW-1:0];
				cap_s2[i] <= |mag[DW-1:MW];
			end
		end
	end

	// Stage 3: squares, capped for flagged magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				sq_s3[i] <= cap_s2[i] ? vms_pkg::SQ_CAP : SW'(mag_s2[i] * mag_s2[i]);
			end
		end
	end

	// Stage 4: normal and shear sums.
	always_ff @(posedge clk) begin
		if (en) begin
			normal_s4 <= UW'(sq_s3[0]) + UW'(sq_s3[1]) + UW'(sq_s3[2]);
			shear_s4  <= UW'(sq_s3[3]) + UW'(sq_s3[4]) + UW'(sq_s3[5]);
		end
	end

	// Stage 5: half the normal sum plus three times the shear sum.
	assign q_sum = QW'(normal_s4 >> 1) + QW'(shear_s4) + (QW'(shear_s4) << 1);

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s5 <= |q_sum[QW-1:RW];
			rad_s5 <= q_sum[RW-1:0];
		end
	end

	// The root chain starts with an empty remainder and root.
	assign step_o = {v_s5, sat_s5, rad_s5, {vms_pkg::REM_W{1'b0}},
		{vms_pkg::ROOT_W{1'b0}}};

endmodule

// ===== rtl/vms_root_cell.sv =====
module vms_root_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  vms_pkg::root_step_t step_i,
	output vms_pkg::root_step_t step_o
);

	localparam int RW = vms_pkg::RAD_W;
	localparam int EW = vms_pkg::REM_W;
	localparam int OW = vms_pkg::ROOT_W;

	logic [EW+1:0] rem_sh;
	logic [EW+1:0] trial;
	logic          take;
	logic [EW+1:0] rem_diff;

	// One digit of the root: bring down two radicand bits and try the next bit.
	assign rem_sh   = {step_i.rem, step_i.rad[RW-1:RW-2]};
	assign trial    = (EW + 2)'({step_i.root, 2'b01});
	assign take     = rem_sh >= trial;
	assign rem_diff = take ? rem_sh - trial : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_o <= '0;
		end else if (en) begin
			step_o.valid <= step_i.valid;
			step_o.sat   <= step_i.sat;
			step_o.rad   <= {step_i.rad[RW-3:0], 2'b00};
			step_o.rem   <= rem_diff[EW-1:0];
			step_o.root  <= {step_i.root[OW-2:0], take};
		end
	end

endmodule

// ===== rtl/von_mises_stress_core.sv =====
// Von Mises equivalent stress: each item of six signed stress components yields
// floor(sqrt(((xx-yy)^2 + (yy-zz)^2 + (zz-xx)^2) / 2 + 3*(xy^2 + yz^2 + xz^2))),
// saturated at 2**26 - 1. With the mode bit from cfg_data cleared, zz, yz and xz
// count as zero. One item is taken every cycle while in_stall is low. An item
// passes through the front stages that form the invariant (difference, magnitude,
// multiply, sum, combine), the chain of square root cells at one result bit per
// cell, and the output register. A skid register behind the output holds one
// result, so an output stall does not stop the pipeline at once;
// in_stall rises only while that skid register is full. Configuration writes
// are always ready and take effect on the next item accepted.
module von_mises_stress_core #(
	parameter int STRESS_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [STRESS_WIDTH-1:0]    normal_x,
	input  logic signed [STRESS_WIDTH-1:0]    normal_y,
	input  logic signed [STRESS_WIDTH-1:0]    normal_z,
	input  logic signed [STRESS_WIDTH-1:0]    shear_xy,
	input  logic signed [STRESS_WIDTH-1:0]    shear_yz,
	input  logic signed [STRESS_WIDTH-1:0]    shear_xz,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [vms_pkg::ROOT_W-1:0]        equivalent_stress
);

	localparam int NS = vms_pkg::ROOT_STEPS;
	localparam int OW = vms_pkg::ROOT_W;

	logic                mode_q;
	logic                en;
	logic                out_valid_q;
	logic [OW-1:0]       out_data_q;
	logic                skid_full_q;
	logic [OW-1:0]       skid_data_q;
	logic                out_take;
	logic [OW-1:0]       last_value;
	vms_pkg::root_step_t chain [NS+1];

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// The whole pipeline advances unless the skid register holds an item.
	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	vms_front #(
		.STRESS_WIDTH(STRESS_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.full_3d  (mode_q),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z),
		.shear_xy (shear_xy),
		.shear_yz (shear_yz),
		.shear_xz (shear_xz),
		.step_o   (chain[0])
	);

	// Chain of square root cells, one result bit each.
	for (genvar g = 0; g < NS; g++) begin : g_cell
		vms_root_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step_i (chain[g]),
			.step_o (chain[g+1])
		);
	end

	assign last_value = chain[NS].sat ? {OW{1'b1}} : chain[NS].root;
	assign out_take   = out_valid_q && !out_stall;

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_take) begin
				skid_full_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= chain[NS].valid;
		end else if (chain[NS].valid) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_take) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || out_take) begin
			out_data_q <= last_value;
		end else begin
			skid_data_q <= last_value;
		end
	end

	assign out_valid         = out_valid_q;
	assign equivalent_stress = out_data_q;

	// The skid register only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid register full with empty output register");

	// A held result is never dropped.
	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result lost");

	// A held skid item stays until the output is taken.
	a_skid_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && out_stall) |=> skid_full_q)
		else $error("skid item lost under stall");

	// The chain is frozen while the skid register is full.
	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |=> $stable(chain[NS].valid) && $stable(chain[0].valid))
		else $error("pipeline moved while skid register full");

endmodule

// ===== dv/von_mises_stress_checker.sv =====
// Watches the three channels of the stress core, predicts each equivalent
// stress from the accepted item and the current mode, and compares results in order.
module von_mises_stress_checker #(
	parameter int STRESS_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic                           cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic signed [STRESS_WIDTH-1:0] normal_x,
	input  logic signed [STRESS_WIDTH-1:0] normal_y,
	input  logic signed [STRESS_WIDTH-1:0] normal_z,
	input  logic signed [STRESS_WIDTH-1:0] shear_xy,
	input  logic signed [STRESS_WIDTH-1:0] shear_yz,
	input  logic signed [STRESS_WIDTH-1:0] shear_xz,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [vms_pkg::ROOT_W-1:0]     equivalent_stress,
	output int                             fail_count,
	output int                             pending,
	output int                             items_taken,
	output int                             results_checked
);

	localparam longint unsigned STRESS_MAX = (64'd1 << vms_pkg::ROOT_W) - 1;
	localparam longint unsigned MAG_LIMIT  = 64'd1 << vms_pkg::MAG_W;
	localparam longint unsigned SQUARE_CAP = 64'd1 << (2 * vms_pkg::MAG_W);

	logic                       full_mode;
	logic [vms_pkg::ROOT_W-1:0] expected_stress[$];
	logic [vms_pkg::ROOT_W-1:0] wanted;

	// Once a magnitude is this large the result can only saturate, so the square is capped.
	function automatic longint unsigned capped_square(input longint d);
		longint unsigned mag;
		mag = (d < 0) ? -d : d;
		if (mag >= MAG_LIMIT)
			return SQUARE_CAP;
		return mag * mag;
	endfunction

	// Three times J2 in exact integers, then the floor of its square root, saturated.
	function automatic logic [vms_pkg::ROOT_W-1:0] predict_stress(
		input logic                           full,
		input logic signed [STRESS_WIDTH-1:0] nx,
		input logic signed [STRESS_WIDTH-1:0] ny,
		input logic signed [STRESS_WIDTH-1:0] nz,
		input logic signed [STRESS_WIDTH-1:0] sxy,
		input logic signed [STRESS_WIDTH-1:0] syz,
		input logic signed [STRESS_WIDTH-1:0] sxz
	);
		longint          xx, yy, zz, xy, yz, xz;
		longint unsigned normal_sum, shear_sum, q, rem, root, probe;
		xx = nx;
		yy = ny;
		xy = sxy;
		zz = 0;
		yz = 0;
		xz = 0;
		// In plane mode the out-of-plane components simply stay at zero.
		if (full) begin
			zz = nz;
			yz = syz;
			xz = sxz;
		end
		normal_sum = capped_square(xx - yy) + capped_square(yy - zz) + capped_square(zz - xx);
		shear_sum  = capped_square(xy) + capped_square(yz) + capped_square(xz);
		q = (normal_sum >> 1) + 64'd3 * shear_sum;

		// Digit-by-digit integer square root.
		rem   = q;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe >>= 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		if (root > STRESS_MAX)
			root = STRESS_MAX;
		return root[vms_pkg::ROOT_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] stress check: %s", $time, what);
		fail_count++;
	endtask

	// Results are checked before new items are queued; the latency keeps them apart anyway.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_mode = 1'b1;
			expected_stress.delete();
			fail_count      = 0;
			pending         = 0;
			items_taken     = 0;
			results_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_stress.size() == 0) begin
					report_mismatch($sformatf("result %0d with no item outstanding",
						equivalent_stress));
				end else begin
					wanted = expected_stress.pop_front();
					results_checked++;
					if (equivalent_stress !== wanted)
						report_mismatch($sformatf("equivalent_stress %0d, expected %0d",
							equivalent_stress, wanted));
				end
			end
			if (in_valid && !in_stall) begin
				expected_stress = {expected_stress, predict_stress(full_mode, normal_x,
					normal_y, normal_z, shear_xy, shear_yz, shear_xz)};
				items_taken++;
			end
			// A mode write applies to items accepted after it.
			if (cfg_valid && cfg_ready)
				full_mode = cfg_data;
			pending = expected_stress.size();
		end
	end

endmodule

// ===== dv/von_mises_stress_core_test.sv =====
module von_mises_stress_core_test;

	localparam int SW = 24;
	localparam logic signed [SW-1:0] S_MAX = 24'sh7fffff;
	localparam logic signed [SW-1:0] S_MIN = 24'sh800000;
	localparam logic signed [SW-1:0] S_ONE = 24'sh000001;
	localparam logic signed [SW-1:0] S_NEG = 24'shffffff;
	localparam logic                 MODE_PLANE = 1'b0;
	localparam logic                 MODE_FULL  = 1'b1;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic                       cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SW-1:0]       normal_x, normal_y, normal_z;
	logic signed [SW-1:0]       shear_xy, shear_yz, shear_xz;
	logic                       out_valid;
	logic                       out_stall;
	logic [vms_pkg::ROOT_W-1:0] equivalent_stress;

	int fail_count, pending, items_taken, results_checked;
	int idle_pct  = 0;
	int stall_pct = 0;

	von_mises_stress_core #(
		.STRESS_WIDTH(SW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.shear_xy(shear_xy),
		.shear_yz(shear_yz),
		.shear_xz(shear_xz),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.equivalent_stress(equivalent_stress)
	);

	von_mises_stress_checker #(
		.STRESS_WIDTH(SW)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.shear_xy(shear_xy),
		.shear_yz(shear_yz),
		.shear_xz(shear_xz),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.equivalent_stress(equivalent_stress),
		.fail_count(fail_count),
		.pending(pending),
		.items_taken(items_taken),
		.results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	// The receiver stalls at random, decided afresh each cycle.
	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Offer one item after a random idle spell and hold it until accepted.
	task automatic push_item(
		input logic signed [SW-1:0] nx, ny, nz,
		input logic signed [SW-1:0] sxy, syz, sxz
	);
		int idle;
		idle = 0;
		while ($urandom_range(99) < idle_pct)
			idle++;
		repeat (idle) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		normal_x <= nx;
		normal_y <= ny;
		normal_z <= nz;
		shear_xy <= sxy;
		shear_yz <= syz;
		shear_xz <= sxz;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Stop sending and let every outstanding item come out, plus some settling time.
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_mode(input logic mode);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mix of full-width noise, extremes, small values and positive or negative values of random magnitude.
	function automatic logic signed [SW-1:0] rand_component();
		logic signed [SW-1:0] v;
		case ($urandom_range(3))
			0: v = SW'($urandom);
			1: begin
				case ($urandom_range(4))
					0: v = S_MAX;
					1: v = S_MIN;
					2: v = S_ONE;
					3: v = S_NEG;
					default: v = '0;
				endcase
			end
			2: v = SW'($urandom_range(2047)) - SW'(1024);
			default: begin
				v = SW'($urandom >> (9 + $urandom_range(23)));
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic random_item;
		logic signed [SW-1:0] base;
		base = rand_component();
		case ($urandom_range(9))
			// Nearly hydrostatic state: the normals differ only slightly.
			6, 7: push_item(base, base + SW'($urandom_range(63)) - SW'(32),
				base + SW'($urandom_range(63)) - SW'(32), rand_component(),
				rand_component(), rand_component());
			// Tiny shears on top of random normals.
			8: push_item(base, rand_component(), rand_component(),
				SW'($urandom_range(7)) - SW'(4), SW'($urandom_range(7)) - SW'(4), '0);
			default: push_item(base, rand_component(), rand_component(),
				rand_component(), rand_component(), rand_component());
		endcase
	endtask

	initial begin
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		in_valid  = 1'b0;
		normal_x  = '0;
		normal_y  = '0;
		normal_z  = '0;
		shear_xy  = '0;
		shear_yz  = '0;
		shear_xz  = '0;
		out_stall = 1'b0;
		arst_n    = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed full-state items: zero, hydrostatic, extremes, pure shear, bit patterns.
		set_mode(MODE_FULL);
		push_item('0, '0, '0, '0, '0, '0);
		push_item(S_MAX, S_MAX, S_MAX, '0, '0, '0);
		push_item(S_MIN, S_MIN, S_MIN, '0, '0, '0);
		push_item(S_MAX, S_MIN, '0, '0, '0, '0);
		push_item(S_MIN, S_MAX, S_MAX, '0, '0, '0);
		push_item('0, '0, '0, S_MAX, '0, '0);
		push_item('0, '0, '0, S_MIN, S_MIN, S_MIN);
		push_item(S_MAX, S_MIN, '0, S_MIN, S_MIN, S_MIN);
		push_item(S_ONE, '0, '0, '0, '0, '0);
		push_item(S_NEG, S_ONE, '0, '0, '0, S_NEG);
		push_item(24'sd3, 24'sd4, 24'sd5, 24'sd6, 24'sd7, 24'sd8);
		push_item(24'sh555555, 24'shaaaaaa, 24'sh555555, 24'shaaaaaa, 24'sh555555,
			24'shaaaaaa);

		// Plane mode: the out-of-plane components carry values that must be ignored.
		set_mode(MODE_PLANE);
		push_item(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN);
		push_item('0, '0, S_MAX, '0, S_MIN, S_MAX);
		push_item(S_ONE, S_NEG, S_MIN, '0, S_MAX, S_MAX);
		push_item('0, '0, S_MIN, S_MAX, S_MIN, S_MIN);
		push_item(S_MIN, S_MIN, S_MAX, '0, S_MAX, S_MAX);
		push_item(S_MAX, '0, S_NEG, S_MIN, S_ONE, S_NEG);
		push_item(24'shaaaaaa, 24'sh555555, 24'shaaaaaa, 24'sh555555, 24'shaaaaaa,
			24'sh555555);

		// Random part: four handshake patterns, each in both modes.
		for (int chunk = 0; chunk < 8; chunk++) begin
			case (chunk >> 1)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			set_mode((chunk % 2 == 0) ? MODE_FULL : MODE_PLANE);
			repeat (138) random_item();
		end

		drain();
		$display("Covered %0d stress items and checked %0d results in full and plane modes,",
			items_taken, results_checked);
		$display("with free flow, sender gaps, receiver stalls and both together.");
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
